@@ rtl/core/hlcd_pkg.sv @@
// ----------------------------------------------------------------------------
// hlcd_pkg
// Shared types and constants of the header/length/checksum deframer.
// ----------------------------------------------------------------------------
`default_nettype none

package hlcd_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned INDEX_W     = 6;
    localparam int unsigned OUT_TDATA_W = 16;

    typedef struct packed {
        logic wr;
        logic hdr;
        logic len;
        logic body;
        logic emit_start;
        logic emit_next;
    } t_dp_cmd;

    typedef struct packed {
        logic is_header;
        logic len_bad;
        logic len_zero;
        logic at_end;
        logic sum_ok;
        logic emit_last;
    } t_dp_status;

endpackage

`default_nettype wire

@@ rtl/core/hlcd_ram.sv @@
// ----------------------------------------------------------------------------
// hlcd_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 62
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire logic [WIDTH-1:0]         i_wr_data,
    input  wire logic                     i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic      [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

`default_nettype wire

@@ rtl/core/hlcd_dp.sv @@
// ----------------------------------------------------------------------------
// hlcd_dp
// Deframer datapath: header register, frame position, length, running sum,
// emit index and the frame store.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_dp #(
    parameter int unsigned MAX_CMD_BYTES = 64
) (
    input  wire logic                           i_clk,
    input  wire logic                           i_rst_n,
    input  wire logic                           i_cfg_wr_en,
    input  wire logic [hlcd_pkg::BYTE_W-1:0]    i_cfg_wr_data,
    input  wire logic [hlcd_pkg::BYTE_W-1:0]    i_rx_byte,
    input  wire hlcd_pkg::t_dp_cmd              i_cmd,
    output hlcd_pkg::t_dp_status                o_status,
    output logic      [hlcd_pkg::BYTE_W-1:0]    o_frame_byte,
    output logic      [hlcd_pkg::INDEX_W-1:0]   o_byte_index
);

    localparam int unsigned DEPTH = MAX_CMD_BYTES - 2;
    localparam int unsigned AW    = $clog2(DEPTH);
    localparam logic [hlcd_pkg::BYTE_W-1:0] LEN_MAX = hlcd_pkg::BYTE_W'(MAX_CMD_BYTES - 4);

    logic [hlcd_pkg::BYTE_W-1:0] r_header_byte;
    logic [AW-1:0]               r_pos,  n_pos;
    logic [AW-1:0]               r_end,  n_end;
    logic [hlcd_pkg::BYTE_W-1:0] r_sum,  n_sum;
    logic [AW-1:0]               r_idx,  n_idx;
    logic [AW-1:0]               wr_addr;
    logic [AW-1:0]               rd_addr;
    logic                        rd_en;

    always_comb begin
        n_pos = r_pos;
        n_end = r_end;
        n_sum = r_sum;
        n_idx = r_idx;
        if (i_cmd.hdr) begin
            n_pos = AW'(1);
            n_sum = '0;
        end
        if (i_cmd.len) begin
            n_end = i_rx_byte[AW-1:0] + AW'(1);
            n_sum = i_rx_byte;
            n_pos = AW'(2);
        end
        if (i_cmd.body) begin
            n_sum = r_sum + i_rx_byte;
            n_pos = r_pos + AW'(1);
        end
        if (i_cmd.emit_start) begin
            n_idx = '0;
        end
        if (i_cmd.emit_next) begin
            n_idx = r_idx + AW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_byte <= '0;
            r_pos         <= '0;
            r_end         <= '0;
            r_sum         <= '0;
            r_idx         <= '0;
        end else begin
            if (i_cfg_wr_en) begin
                r_header_byte <= i_cfg_wr_data;
            end
            r_pos <= n_pos;
            r_end <= n_end;
            r_sum <= n_sum;
            r_idx <= n_idx;
        end
    end

    assign wr_addr = i_cmd.hdr ? '0 : r_pos;
    assign rd_en   = i_cmd.emit_start | i_cmd.emit_next;
    assign rd_addr = i_cmd.emit_start ? '0 : (r_idx + AW'(1));

    hlcd_ram #(
        .WIDTH (hlcd_pkg::BYTE_W),
        .DEPTH (DEPTH)
    ) u_store (
        .i_clk     (i_clk),
        .i_wr_en   (i_cmd.wr),
        .i_wr_addr (wr_addr),
        .i_wr_data (i_rx_byte),
        .i_rd_en   (rd_en),
        .i_rd_addr (rd_addr),
        .o_rd_data (o_frame_byte)
    );

    always_comb begin
        o_status.is_header = (i_rx_byte == r_header_byte);
        o_status.len_bad   = (i_rx_byte > LEN_MAX);
        o_status.len_zero  = (i_rx_byte == '0);
        o_status.at_end    = (r_pos == r_end);
        o_status.sum_ok    = (r_sum == i_rx_byte);
        o_status.emit_last = (r_idx == r_end);
    end

    assign o_byte_index = hlcd_pkg::INDEX_W'(r_idx);

`ifndef SYNTHESIS
    a_idx_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit_next |=> r_idx == $past(r_idx) + AW'(1))
        else $error("emit index did not advance by one");

    a_len_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.len |=> r_end != '0 && r_pos == AW'(2))
        else $error("length capture left bad end or position");

    a_hdr_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hdr |=> r_pos == AW'(1) && r_sum == '0)
        else $error("header capture left bad position or sum");
`endif

endmodule

`default_nettype wire

@@ rtl/core/hlcd_ctrl.sv @@
// ----------------------------------------------------------------------------
// hlcd_ctrl
// Deframer controller: hunt, length, body collect and frame emit sequencing.
// ----------------------------------------------------------------------------
`default_nettype none

module hlcd_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    input  wire logic                 i_out_ready,
    input  wire hlcd_pkg::t_dp_status i_status,
    output hlcd_pkg::t_dp_cmd         o_cmd,
    output logic                      o_in_ready,
    output logic                      o_out_valid
);

    localparam logic [1:0] ST_HUNT = 2'd0;
    localparam logic [1:0] ST_LEN  = 2'd1;
    localparam logic [1:0] ST_BODY = 2'd2;
    localparam logic [1:0] ST_SEND = 2'd3;

    logic [1:0] r_state, n_state;
    logic       in_fire;
    logic       out_fire;

    assign o_in_ready  = (r_state != ST_SEND);
    assign o_out_valid = (r_state == ST_SEND);
    assign in_fire     = i_in_valid & o_in_ready;
    assign out_fire    = i_out_ready & o_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            ST_HUNT: begin
                if (in_fire && i_status.is_header) begin
                    o_cmd.wr  = 1'b1;
                    o_cmd.hdr = 1'b1;
                    n_state   = ST_LEN;
                end
            end
            ST_LEN: begin
                if (in_fire) begin
                    if (i_status.len_bad) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.wr  = 1'b1;
                        o_cmd.len = 1'b1;
                        if (i_status.len_zero) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = ST_SEND;
                        end else begin
                            n_state = ST_BODY;
                        end
                    end
                end
            end
            ST_BODY: begin
                if (in_fire) begin
                    o_cmd.wr = 1'b1;
                    if (i_status.at_end) begin
                        if (i_status.sum_ok) begin
                            o_cmd.emit_start = 1'b1;
                            n_state          = ST_SEND;
                        end else begin
                            n_state = ST_HUNT;
                        end
                    end else begin
                        o_cmd.body = 1'b1;
                    end
                end
            end
            ST_SEND: begin
                if (out_fire) begin
                    if (i_status.emit_last) begin
                        n_state = ST_HUNT;
                    end else begin
                        o_cmd.emit_next = 1'b1;
                    end
                end
            end
            default: begin
                n_state = ST_HUNT;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_HUNT;
        end else begin
            r_state <= n_state;
        end
    end

`ifndef SYNTHESIS
    a_last_to_hunt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (out_fire && i_status.emit_last) |=> r_state == ST_HUNT)
        else $error("controller did not return to hunt after last byte");

    a_send_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_SEND && !i_out_ready) |=> r_state == ST_SEND)
        else $error("emit abandoned while output stalled");

    a_bad_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LEN && in_fire && i_status.len_bad) |=> r_state == ST_HUNT)
        else $error("oversized length did not restart the hunt");
`endif

endmodule

`default_nettype wire

@@ rtl/core/header_length_checksum_deframer_unit.sv @@
// ----------------------------------------------------------------------------
// header_length_checksum_deframer_unit
// Hunts for a header byte, reads a length byte, checks a mod-256 checksum and
// replays the validated frame one byte per output item.
//
//   channel  | dir | handshake               | payload
//   ---------+-----+-------------------------+-------------------------------
//   s_axis   | in  | tvalid / tready         | tdata[7:0] rx_byte
//   m_axis   | out | tvalid / tready / tlast | tdata[7:0] frame_byte,
//            |     |                         | tdata[13:8] byte_index
//   cfg      | in  | i_cfg_wr_en             | i_cfg_wr_data header_byte
//
// Input bytes are accepted one per cycle while a frame is collected.
// Frame replay reads the frame store one byte per cycle while the sink does
// not stall; input is held off for the whole replay.
// Output stalls freeze the replay; the output handshake sets that pace.
// Reset (synchronous, active low) returns to header hunt, header_byte 0.
// ----------------------------------------------------------------------------
`default_nettype none

module header_length_checksum_deframer_unit #(
    parameter int unsigned MAX_CMD_BYTES = 64
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                s_axis_tvalid,
    output logic                                     s_axis_tready,
    input  wire logic [hlcd_pkg::BYTE_W-1:0]         s_axis_tdata,  // [7:0] rx_byte
    output logic                                     m_axis_tvalid,
    input  wire logic                                m_axis_tready,
    output logic      [hlcd_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,  // [7:0] frame_byte,
                                                                    // [13:8] byte_index
    output logic                                     m_axis_tlast,
    input  wire logic                                i_cfg_wr_en,
    input  wire logic [hlcd_pkg::BYTE_W-1:0]         i_cfg_wr_data
);

    hlcd_pkg::t_dp_cmd                  cmd;
    hlcd_pkg::t_dp_status               status;
    logic [hlcd_pkg::BYTE_W-1:0]        frame_byte;
    logic [hlcd_pkg::INDEX_W-1:0]       byte_index;

    hlcd_dp #(
        .MAX_CMD_BYTES (MAX_CMD_BYTES)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_rx_byte     (s_axis_tdata),
        .i_cmd         (cmd),
        .o_status      (status),
        .o_frame_byte  (frame_byte),
        .o_byte_index  (byte_index)
    );

    hlcd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (status),
        .o_cmd       (cmd),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid)
    );

    assign m_axis_tdata = {2'b00, byte_index, frame_byte};
    assign m_axis_tlast = status.emit_last;

endmodule

`default_nettype wire
